/* rtl/mono_bitmap_page_blit_unit_macros.svh */
// Assertion macros for the page framebuffer blit unit.
// Users must have clk and arst_n in scope.
`ifndef MONO_BITMAP_PAGE_BLIT_UNIT_MACROS_SVH
`define MONO_BITMAP_PAGE_BLIT_UNIT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define MBPB_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define MBPB_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/mbpb_pkg.sv */
// Shared types and constants for the page framebuffer blit unit.
// No dependencies.
package mbpb_pkg;

	localparam int BANKS = 8;

	localparam logic [1:0] OPC_BITMAP = 2'd0;
	localparam logic [1:0] OPC_READ   = 2'd1;
	localparam logic [1:0] OPC_CLEAR  = 2'd2;

	localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
	localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
	localparam logic [1:0] CFG_WIDTH    = 2'd2;
	localparam logic [1:0] CFG_HEIGHT   = 2'd3;

	localparam logic KIND_READ    = 1'b0;
	localparam logic KIND_REFRESH = 1'b1;

	typedef enum logic [1:0] {
		CMD_DRAW  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic {
		BK_CLEAR = 1'b0,
		BK_RUN   = 1'b1
	} bk_state_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [BANKS-1:0] bank_en;
		logic [2:0]       bit_sel;
		logic             rd_ok;
		logic [2:0]       rd_bank;
		logic             refresh;
		logic [1:0]       first_page;
		logic [1:0]       last_page;
	} ctrl_t;

	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] read_data;
		logic [1:0] first_page;
		logic [1:0] last_page;
	} res_t;

endpackage

/* rtl/mono_bitmap_page_blit_unit.sv */
// Channel  Dir  Signals                        Beat contents
// cfg      in   cfg_we cfg_index cfg_data      register index, value
// s        in   s_tvalid s_tready s_tdata/tuser bitmap byte, read or clear
// m        out  m_tvalid m_tready m_tdata/tuser read byte or refresh range
// One beat per cycle enters the two-entry queue while s_tready is high; the back stage does
// a read-modify-write across eight column-bank RAMs, one item per cycle unless m stalls; a
// read result passes the RAM read register, then the output register. Reset and each clear
// beat run a sweep of all ((SCREEN_COLUMNS+7)/8)*SCREEN_PAGES RAM rows (64 by default), one
// RAM row per cycle, during which s_tready is low. A stalled m channel holds a read or refresh
// item in the back stage; the queue then fills and drops s_tready.
// Top level of the page framebuffer blit unit. Depends on mbpb_pkg, mbpb_front,
// mbpb_fifo, mbpb_back and the assertion macro header.
`include "mono_bitmap_page_blit_unit_macros.svh"

module mono_bitmap_page_blit_unit #(
	parameter int SCREEN_COLUMNS = 128,
	parameter int SCREEN_PAGES   = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // bitmap_byte[7:0], fb_index[16:8], zero pad
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // read_data[7:0], first_page[9:8], last_page[11:10], zero pad
	output logic [0:0]  m_tuser    // kind[0]
);

	import mbpb_pkg::*;

	localparam int BANK_COLS  = (SCREEN_COLUMNS + 7) / 8;
	localparam int BANK_DEPTH = BANK_COLS * SCREEN_PAGES;
	localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int QW         = $bits(ctrl_t) + BANKS * AW;

	logic                     busy;
	logic                     q_ready;
	logic                     q_valid;
	ctrl_t                    q_ctrl;
	logic [BANKS-1:0][AW-1:0] q_addr;
	logic                     head_valid;
	logic                     head_ready;
	logic [QW-1:0]            head_data;
	ctrl_t                    head_ctrl;
	logic [BANKS-1:0][AW-1:0] head_addr;
	res_t                     res;

	mbpb_front #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_PAGES  (SCREEN_PAGES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.opcode     (s_tuser),
		.bitmap_byte(s_tdata[7:0]),
		.fb_index   (s_tdata[16:8]),
		.busy       (busy),
		.q_ready    (q_ready),
		.q_valid    (q_valid),
		.q_ctrl     (q_ctrl),
		.q_addr     (q_addr)
	);

	mbpb_fifo #(
		.WIDTH(QW)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.in_data  ({q_ctrl, q_addr}),
		.out_valid(head_valid),
		.out_ready(head_ready),
		.out_data (head_data)
	);

	assign head_ctrl = head_data[QW-1 -: $bits(ctrl_t)];
	assign head_addr = head_data[BANKS*AW-1:0];

	mbpb_back #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_PAGES  (SCREEN_PAGES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_ready(head_ready),
		.head_ctrl (head_ctrl),
		.head_addr (head_addr),
		.busy      (busy),
		.res       (res),
		.res_ready (m_tready)
	);

	assign m_tvalid   = res.valid;
	assign m_tuser[0] = res.kind;
	assign m_tdata    = {4'b0000, res.last_page, res.first_page, res.read_data};

	`MBPB_ASSERT(a_no_beat_in_sweep, busy |-> !s_tready, "input beat taken during clearing sweep")
	`MBPB_ASSERT(a_refresh_no_data, (m_tvalid && m_tuser[0] == KIND_REFRESH) |-> (m_tdata[7:0] == 8'd0), "refresh beat carries read data")
	`MBPB_ASSERT(a_read_no_pages, (m_tvalid && m_tuser[0] == KIND_READ) |-> (m_tdata[11:8] == 4'd0), "read beat carries page range")
	`MBPB_ASSERT_NEXT(a_clear_starts_sweep, head_valid && head_ready && head_ctrl.cmd == CMD_CLEAR, busy, "clear beat did not start sweep")

endmodule

/* rtl/mbpb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/mbpb_fifo.sv */
// Two-entry queue between the front and back parts of the blit unit.
// No dependencies.
module mbpb_fifo #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

endmodule

/* rtl/mbpb_front.sv */
// Front part: configuration registers, bitmap counters, item classification
// and per-bank address and mask generation. Depends on mbpb_pkg.
module mbpb_front #(
	parameter int SCREEN_COLUMNS = 128,
	parameter int SCREEN_PAGES   = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [7:0]             cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             opcode,
	input  logic [7:0]             bitmap_byte,
	input  logic [8:0]             fb_index,
	input  logic                   busy,
	input  logic                   q_ready,
	output logic                   q_valid,
	output mbpb_pkg::ctrl_t        q_ctrl,
	output logic [mbpb_pkg::BANKS-1:0]
		[(((SCREEN_COLUMNS + 7) / 8 * SCREEN_PAGES) > 1 ?
		$clog2((SCREEN_COLUMNS + 7) / 8 * SCREEN_PAGES) : 1)-1:0] q_addr
);

	import mbpb_pkg::*;

	localparam int BANK_COLS   = (SCREEN_COLUMNS + 7) / 8;
	localparam int BANK_DEPTH  = BANK_COLS * SCREEN_PAGES;
	localparam int AW          = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int SCREEN_ROWS = SCREEN_PAGES * 8;
	localparam int STORE_BYTES = SCREEN_COLUMNS * SCREEN_PAGES;

	logic [6:0] origin_x_q;
	logic [4:0] origin_y_q;
	logic [7:0] width_q;
	logic [7:0] height_q;
	logic [7:0] row_count_q;
	logic [4:0] byte_in_row_q;

	logic                       accept;
	logic [5:0]                 bpr;
	logic [7:0]                 h;
	logic                       byte_more;
	logic                       row_more;
	logic                       refresh_hit;
	logic [8:0]                 py;
	logic [8:0]                 lp_sum;
	logic [5:0]                 lp_clamp;
	logic [BANKS-1:0]           lane_en;
	logic [BANKS-1:0][AW-1:0]   draw_addr;
	logic [2:0]                 rd_page;
	logic [7:0]                 rd_col;
	logic [AW-1:0]              rd_addr;

	assign in_ready = q_ready && !busy;
	assign accept   = in_valid && in_ready;

	always_comb begin
		bpr = 6'(({1'b0, width_q} + 9'd7) >> 3);
		if (bpr == 6'd0) begin
			bpr = 6'd1;
		end
		h           = (height_q == 8'd0) ? 8'd1 : height_q;
		byte_more   = ({1'b0, byte_in_row_q} + 6'd1) < bpr;
		row_more    = ({1'b0, row_count_q} + 9'd1) < {1'b0, h};
		refresh_hit = !byte_more && !row_more && (int'(origin_x_q) < SCREEN_COLUMNS)
			&& (int'(origin_y_q) < SCREEN_ROWS);
		lp_sum      = {4'b0, origin_y_q} + {1'b0, h} - 9'd1;
		lp_clamp    = lp_sum[8:3];
		if (int'(lp_clamp) > SCREEN_PAGES - 1) begin
			lp_clamp = 6'(SCREEN_PAGES - 1);
		end
	end

	always_comb begin
		logic [2:0] k;
		logic [7:0] col;
		logic [8:0] px;
		int         a;
		k  = '0;
		col = '0;
		px = '0;
		a  = 0;
		py = {4'b0, origin_y_q} + {1'b0, row_count_q};
		for (int j = 0; j < BANKS; j++) begin
			k   = 3'(j) - origin_x_q[2:0];
			col = {byte_in_row_q, 3'b000} + {5'b0, k};
			px  = {2'b0, origin_x_q} + {1'b0, col};
			lane_en[j] = bitmap_byte[3'd7 - k] && (col < width_q)
				&& (int'(px) < SCREEN_COLUMNS) && (int'(py) < SCREEN_ROWS);
			a = int'(py[8:3]) * BANK_COLS + int'(px[8:3]);
			draw_addr[j] = a[AW-1:0];
		end
	end

	always_comb begin
		int c;
		int a2;
		rd_page = '0;
		for (int p = 1; p < SCREEN_PAGES; p++) begin
			if (int'(fb_index) >= p * SCREEN_COLUMNS) begin
				rd_page = rd_page + 3'd1;
			end
		end
		c       = int'(fb_index) - int'(rd_page) * SCREEN_COLUMNS;
		rd_col  = c[7:0];
		a2      = int'(rd_page) * BANK_COLS + int'(rd_col[7:3]);
		rd_addr = a2[AW-1:0];
	end

	always_comb begin
		q_ctrl  = '0;
		q_addr  = draw_addr;
		q_valid = 1'b0;
		case (opcode)
			OPC_BITMAP: begin
				q_valid            = accept;
				q_ctrl.cmd         = CMD_DRAW;
				q_ctrl.bank_en     = lane_en;
				q_ctrl.bit_sel     = py[2:0];
				q_ctrl.refresh     = refresh_hit;
				q_ctrl.first_page  = origin_y_q[4:3];
				q_ctrl.last_page   = lp_clamp[1:0];
			end
			OPC_READ: begin
				q_valid        = accept;
				q_ctrl.cmd     = CMD_READ;
				q_ctrl.rd_ok   = int'(fb_index) < STORE_BYTES;
				q_ctrl.rd_bank = rd_col[2:0];
				for (int j = 0; j < BANKS; j++) begin
					q_addr[j] = rd_addr;
				end
			end
			OPC_CLEAR: begin
				q_valid    = accept;
				q_ctrl.cmd = CMD_CLEAR;
			end
			default: begin
				q_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= 7'd0;
			origin_y_q <= 5'd0;
			width_q    <= 8'd8;
			height_q   <= 8'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIGIN_X: origin_x_q <= cfg_data[6:0];
				CFG_ORIGIN_Y: origin_y_q <= cfg_data[4:0];
				CFG_WIDTH:    width_q    <= cfg_data;
				CFG_HEIGHT:   height_q   <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q   <= 8'd0;
			byte_in_row_q <= 5'd0;
		end else if (accept) begin
			case (opcode)
				OPC_BITMAP: begin
					if (byte_more) begin
						byte_in_row_q <= byte_in_row_q + 5'd1;
					end else begin
						byte_in_row_q <= 5'd0;
						row_count_q   <= row_more ? row_count_q + 8'd1 : 8'd0;
					end
				end
				OPC_CLEAR: begin
					row_count_q   <= 8'd0;
					byte_in_row_q <= 5'd0;
				end
				default: ;
			endcase
		end
	end

endmodule

/* rtl/mbpb_back.sv */
// Back part: eight column-bank RAMs, read-modify-write stage, clearing
// sweep and the output register. Depends on mbpb_pkg and mbpb_ram.
module mbpb_back #(
	parameter int SCREEN_COLUMNS = 128,
	parameter int SCREEN_PAGES   = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	output logic                   head_ready,
	input  mbpb_pkg::ctrl_t        head_ctrl,
	input  logic [mbpb_pkg::BANKS-1:0]
		[(((SCREEN_COLUMNS + 7) / 8 * SCREEN_PAGES) > 1 ?
		$clog2((SCREEN_COLUMNS + 7) / 8 * SCREEN_PAGES) : 1)-1:0] head_addr,
	output logic                   busy,
	output mbpb_pkg::res_t         res,
	input  logic                   res_ready
);

	import mbpb_pkg::*;

	localparam int BANK_COLS  = (SCREEN_COLUMNS + 7) / 8;
	localparam int BANK_DEPTH = BANK_COLS * SCREEN_PAGES;
	localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

	bk_state_t state_q;
	bk_state_t state_d;
	logic [AW-1:0] sweep_q;
	logic          sweep_done;
	logic          sweeping;

	logic                     s1_valid_q;
	ctrl_t                    s1_ctrl_s1;
	logic [BANKS-1:0][AW-1:0] s1_addr_s1;

	logic [BANKS-1:0]         fwd_we_q;
	logic [BANKS-1:0][AW-1:0] fwd_addr_q;
	logic [BANKS-1:0][7:0]    fwd_data_q;

	logic [BANKS-1:0]         we;
	logic [BANKS-1:0][AW-1:0] waddr;
	logic [BANKS-1:0][7:0]    wdata;
	logic [BANKS-1:0][7:0]    rdata;
	logic [BANKS-1:0][7:0]    merged;

	logic       res_valid_q;
	logic       res_kind_q;
	logic [7:0] res_data_q;
	logic [1:0] res_first_q;
	logic [1:0] res_last_q;

	logic out_free;
	logic s1_needs_out;
	logic s1_advance;
	logic pop;

	assign sweep_done   = (sweep_q == AW'(BANK_DEPTH - 1));
	assign out_free     = !res_valid_q || res_ready;
	assign s1_needs_out = (s1_ctrl_s1.cmd == CMD_READ) || s1_ctrl_s1.refresh;
	assign s1_advance   = s1_valid_q && (!s1_needs_out || out_free);
	assign pop          = (state_q == BK_RUN) && head_valid && (!s1_valid_q || s1_advance);
	assign head_ready   = pop;
	assign res          = {res_valid_q, res_kind_q, res_data_q, res_first_q, res_last_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR: begin
				if (sweep_done) begin
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (pop && head_ctrl.cmd == CMD_CLEAR) begin
					state_d = BK_CLEAR;
				end
			end
			default: state_d = BK_CLEAR;
		endcase
	end

	always_comb begin
		busy     = 1'b0;
		sweeping = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				busy     = 1'b1;
				sweeping = 1'b1;
			end
			BK_RUN: begin
				busy     = 1'b0;
				sweeping = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			sweep_q <= sweeping ? sweep_q + AW'(1) : '0;
		end
	end

	always_comb begin
		for (int j = 0; j < BANKS; j++) begin
			merged[j] = (fwd_we_q[j] && fwd_addr_q[j] == s1_addr_s1[j]) ? fwd_data_q[j]
				: rdata[j];
			if (sweeping) begin
				we[j]    = 1'b1;
				waddr[j] = sweep_q;
				wdata[j] = 8'd0;
			end else begin
				we[j]    = s1_advance && (s1_ctrl_s1.cmd == CMD_DRAW) && s1_ctrl_s1.bank_en[j];
				waddr[j] = s1_addr_s1[j];
				wdata[j] = merged[j] | (8'd1 << s1_ctrl_s1.bit_sel);
			end
		end
	end

	for (genvar j = 0; j < BANKS; j++) begin : g_bank
		mbpb_ram #(
			.WIDTH(8),
			.DEPTH(BANK_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (we[j]),
			.waddr(waddr[j]),
			.wdata(wdata[j]),
			.re   (pop),
			.raddr(head_addr[j]),
			.rdata(rdata[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_we_q   <= '0;
		end else begin
			if (pop) begin
				s1_valid_q <= (head_ctrl.cmd != CMD_CLEAR);
				fwd_we_q   <= we;
			end else if (s1_advance) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			s1_ctrl_s1 <= head_ctrl;
			s1_addr_s1 <= head_addr;
			fwd_addr_q <= waddr;
			fwd_data_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_advance && s1_needs_out) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && s1_needs_out) begin
			if (s1_ctrl_s1.cmd == CMD_READ) begin
				res_kind_q  <= KIND_READ;
				res_data_q  <= s1_ctrl_s1.rd_ok ? merged[s1_ctrl_s1.rd_bank] : 8'd0;
				res_first_q <= 2'd0;
				res_last_q  <= 2'd0;
			end else begin
				res_kind_q  <= KIND_REFRESH;
				res_data_q  <= 8'd0;
				res_first_q <= s1_ctrl_s1.first_page;
				res_last_q  <= s1_ctrl_s1.last_page;
			end
		end
	end

endmodule
